FILE: design/sntsalu_pkg.sv
// ----------------------------------------------------------------------------
// sntsalu_pkg
// shared constants, request codes and pipeline payload type of the
// seconds plus nanoseconds timestamp unit
// ----------------------------------------------------------------------------
package sntsalu_pkg;

  // signed width of a seconds count inside the unit
  localparam int SEC_WIDTH  = 64;
  // width of the seconds sums that carry range checks
  localparam int SUM_W      = 66;
  // number of register stages
  localparam int PIPE_DEPTH = 10;
  localparam int PIPE_LAST  = PIPE_DEPTH - 1;

  localparam logic [29:0] NS_PER_S = 30'd1000000000;

  // 1e9 = 2^9 * 1953125; quotient of (span >> 9) by 1953125 through
  // reciprocal floor(2^54 / 1953125), estimate low by at most one
  localparam int          NS_POW2     = 9;
  localparam logic [33:0] RECIP       = 34'd9223372036;
  localparam int          RECIP_SHIFT = 54;
  localparam int          PROD_W      = 88;

  // seconds difference limit for the nanosecond difference
  localparam logic signed [64:0] DIFF_LIMIT   = 65'sd9223372035;
  localparam logic signed [64:0] DIFF_LIMIT_N = -65'sd9223372035;

  // signed seconds range, sign extended to SUM_W bits
  localparam logic [SUM_W-1:0] SEC_MAX = {{(SUM_W-SEC_WIDTH+1){1'b0}}, {(SEC_WIDTH-1){1'b1}}};
  localparam logic [SUM_W-1:0] SEC_MIN = {{(SUM_W-SEC_WIDTH+1){1'b1}}, {(SEC_WIDTH-1){1'b0}}};

  // signed 64-bit range, sign extended to SUM_W bits
  localparam logic [SUM_W-1:0] SPAN_MAX = {{(SUM_W-63){1'b0}}, {63{1'b1}}};
  localparam logic [SUM_W-1:0] SPAN_MIN = {{(SUM_W-63){1'b1}}, {63{1'b0}}};

  typedef enum logic [2:0] {
    OP_NORM = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_DIFF = 3'd3,
    OP_CMP  = 3'd4
  } op_t;

  // payload carried through every stage
  typedef struct packed {
    logic [2:0]       op;
    logic [63:0]      a_sec;
    logic [31:0]      a_ns;
    logic             neg;
    logic [63:0]      mag;
    logic [64:0]      dsec;
    logic [32:0]      nsd;
    logic             lt;
    logic             eq;
    logic             gt;
    logic             ovf;
    logic [60:0]      pp_lo;
    logic [61:0]      pp_hi;
    logic [33:0]      dmag;
    logic             dneg;
    logic [33:0]      qe;
    logic [63:0]      dprod;
    logic [30:0]      lo31;
    logic [64:0]      sprod;
    logic [30:0]      rpre;
    logic [63:0]      res_span;
    logic [33:0]      q;
    logic [29:0]      r;
    logic [34:0]      ssec;
    logic [30:0]      sns;
    logic [SUM_W-1:0] t;
    logic [32:0]      nsum;
    logic [2:0]       qn;
    logic [29:0]      rn;
    logic [63:0]      res_sec;
    logic [29:0]      res_nsec;
  } pipe_t;

  // low SEC_WIDTH bits of a seconds word, sign extended to 64 bits
  function automatic logic [63:0] sec_ext(input logic [63:0] raw);
    sec_ext = {{(65 - SEC_WIDTH){raw[SEC_WIDTH-1]}}, raw[SEC_WIDTH-2:0]};
  endfunction

  // k seconds in nanoseconds, 34-bit two's complement
  function automatic logic [33:0] ns_mult(input int k);
    ns_mult = 34'(longint'(k) * longint'(NS_PER_S));
  endfunction

endpackage

FILE: design/sntsalu_if.sv
// ----------------------------------------------------------------------------
// sntsalu_if
// request and result channels of the timestamp unit, valid/ready handshake
// ----------------------------------------------------------------------------

// request channel
interface sntsalu_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [63:0] a_sec;
  logic signed [31:0] a_nsec;
  logic signed [63:0] span_ns;
  logic signed [63:0] b_sec;
  logic [29:0]        b_nsec;

  modport source (
    output valid, req_type, a_sec, a_nsec, span_ns, b_sec, b_nsec,
    input  ready
  );
  modport sink (
    input  valid, req_type, a_sec, a_nsec, span_ns, b_sec, b_nsec,
    output ready
  );
endinterface

// result channel
interface sntsalu_res_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] res_sec;
  logic [29:0]        res_nsec;
  logic signed [63:0] res_span;
  logic               is_less;
  logic               is_equal;
  logic               is_greater;
  logic               overflow;

  modport source (
    output valid, res_sec, res_nsec, res_span, is_less, is_equal, is_greater, overflow,
    input  ready
  );
  modport sink (
    input  valid, res_sec, res_nsec, res_span, is_less, is_equal, is_greater, overflow,
    output ready
  );
endinterface

FILE: design/sec_nsec_timestamp_alu_core.sv
// ----------------------------------------------------------------------------
// sec_nsec_timestamp_alu_core
// seconds plus nanoseconds timestamp unit: normalize, add or subtract a
// nanosecond span, difference in nanoseconds and compare
// ----------------------------------------------------------------------------
//  channel   dir  content
//  in_ch     in   req_type, a_sec, a_nsec, span_ns, b_sec, b_nsec
//  out_ch    out  res_sec, res_nsec, res_span, is_less/equal/greater, overflow
//
//  one request per cycle while out_ch does not stall; each result passes
//  through PIPE_DEPTH register stages on its way to out_ch
//  the stage count is set by the span divide: reciprocal multiply, correction, then
//  seconds add and nanosecond normalize, one step per stage
//  each stage loads when empty or when its content moves on, so a stalled
//  output fills bubbles before in_ch.ready drops
//  synchronous reset clears the stage valid bits only
// ----------------------------------------------------------------------------
module sec_nsec_timestamp_alu_core
  import sntsalu_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  sntsalu_req_if.sink   in_ch,
  sntsalu_res_if.source out_ch
);

  logic [PIPE_DEPTH-1:0] v_r;
  logic [PIPE_DEPTH-1:0] v_in;
  logic [PIPE_DEPTH:0]   adv;
  pipe_t                 st_r   [PIPE_DEPTH];
  pipe_t                 st_nxt [PIPE_DEPTH];

  // stage advance chain, back from the output
  always_comb begin
    adv[PIPE_DEPTH] = out_ch.ready;
    for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign v_in        = {v_r[PIPE_DEPTH-2:0], in_ch.valid};
  assign in_ch.ready = adv[0];

  // stage logic
  always_comb begin
    logic [63:0]      a_x;
    logic [63:0]      b_x;
    logic             sec_lt;
    logic             sec_eq;
    logic             ns_lt;
    logic             ns_gt;
    logic [54:0]      xs;
    logic [64:0]      dabs;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0] tot;
    logic [SUM_W-1:0] rs;
    logic             corr;
    logic [33:0]      ext;
    logic [33:0]      base;
    logic [2:0]       qn_v;

    // stage 1: decode, span magnitude, seconds and nanosecond difference, compare
    a_x    = sec_ext(in_ch.a_sec);
    b_x    = sec_ext(in_ch.b_sec);
    st_nxt[0]       = '0;
    st_nxt[0].op    = in_ch.req_type;
    st_nxt[0].a_sec = a_x;
    st_nxt[0].a_ns  = in_ch.a_nsec;
    st_nxt[0].neg   = in_ch.span_ns[63] ^ (in_ch.req_type == OP_SUB);
    st_nxt[0].mag   = in_ch.span_ns[63] ? (~in_ch.span_ns + 64'd1) : in_ch.span_ns;
    st_nxt[0].dsec  = {a_x[63], a_x} - {b_x[63], b_x};
    st_nxt[0].nsd   = {in_ch.a_nsec[31], in_ch.a_nsec} - {3'b000, in_ch.b_nsec};
    sec_lt = $signed(a_x) < $signed(b_x);
    sec_eq = a_x == b_x;
    ns_lt  = st_nxt[0].nsd[32];
    ns_gt  = !st_nxt[0].nsd[32] && (st_nxt[0].nsd != '0);
    if (in_ch.req_type == OP_CMP) begin
      st_nxt[0].lt = sec_lt || (sec_eq && ns_lt);
      st_nxt[0].gt = (!sec_lt && !sec_eq) || (sec_eq && ns_gt);
      st_nxt[0].eq = !st_nxt[0].lt && !st_nxt[0].gt;
    end

    // stage 2: reciprocal partial products, difference range and magnitude
    st_nxt[1]       = st_r[0];
    xs              = st_r[0].mag[63:NS_POW2];
    st_nxt[1].pp_lo = 61'(xs[26:0]) * 61'(RECIP);
    st_nxt[1].pp_hi = 62'(xs[54:27]) * 62'(RECIP);
    dabs            = st_r[0].dsec[64] ? (~st_r[0].dsec + 65'd1) : st_r[0].dsec;
    st_nxt[1].dmag  = dabs[33:0];
    st_nxt[1].dneg  = st_r[0].dsec[64];
    if (st_r[0].op == OP_DIFF &&
        ($signed(st_r[0].dsec) > DIFF_LIMIT || $signed(st_r[0].dsec) < DIFF_LIMIT_N)) begin
      st_nxt[1].ovf = 1'b1;
    end

    // stage 3: quotient estimate, seconds difference in nanoseconds
    st_nxt[2]       = st_r[1];
    prod            = PROD_W'({st_r[1].pp_hi, 27'd0}) + PROD_W'(st_r[1].pp_lo);
    st_nxt[2].qe    = prod[RECIP_SHIFT +: 34];
    st_nxt[2].dprod = 64'(st_r[1].dmag) * 64'(NS_PER_S);

    // stage 4: low bits of estimate times 1e9, signed difference product
    st_nxt[3]       = st_r[2];
    st_nxt[3].lo31  = st_r[2].qe[30:0] * 31'(NS_PER_S);
    st_nxt[3].sprod = st_r[2].dneg ? (~{1'b0, st_r[2].dprod} + 65'd1)
                                   : {1'b0, st_r[2].dprod};

    // stage 5: remainder estimate, nanosecond difference with range check
    st_nxt[4]      = st_r[3];
    st_nxt[4].rpre = st_r[3].mag[30:0] - st_r[3].lo31;
    tot = {st_r[3].sprod[64], st_r[3].sprod} + {{33{st_r[3].nsd[32]}}, st_r[3].nsd};
    if (st_r[3].op == OP_DIFF && !st_r[3].ovf) begin
      if ($signed(tot) > $signed(SPAN_MAX) || $signed(tot) < $signed(SPAN_MIN)) begin
        st_nxt[4].ovf = 1'b1;
      end else begin
        st_nxt[4].res_span = tot[63:0];
      end
    end

    // stage 6: quotient and remainder correction
    st_nxt[5]   = st_r[4];
    corr        = st_r[4].rpre >= 31'(NS_PER_S);
    st_nxt[5].q = st_r[4].qe + 34'(corr);
    st_nxt[5].r = corr ? 30'(st_r[4].rpre - 31'(NS_PER_S)) : st_r[4].rpre[29:0];

    // stage 7: signed span seconds and nanoseconds, zero for all other requests
    st_nxt[6] = st_r[5];
    if (st_r[5].op == OP_ADD || st_r[5].op == OP_SUB) begin
      st_nxt[6].ssec = st_r[5].neg ? (~{1'b0, st_r[5].q} + 35'd1) : {1'b0, st_r[5].q};
      st_nxt[6].sns  = st_r[5].neg ? (~{1'b0, st_r[5].r} + 31'd1) : {1'b0, st_r[5].r};
    end else begin
      st_nxt[6].ssec = '0;
      st_nxt[6].sns  = '0;
    end

    // stage 8: seconds sum with range check, raw nanosecond sum
    st_nxt[7]      = st_r[6];
    st_nxt[7].t    = {{2{st_r[6].a_sec[63]}}, st_r[6].a_sec}
                   + {{(SUM_W-35){st_r[6].ssec[34]}}, st_r[6].ssec};
    st_nxt[7].nsum = {st_r[6].a_ns[31], st_r[6].a_ns} + {{2{st_r[6].sns[30]}}, st_r[6].sns};
    if ((st_r[6].op == OP_NORM || st_r[6].op == OP_ADD || st_r[6].op == OP_SUB) &&
        ($signed(st_nxt[7].t) > $signed(SEC_MAX) ||
         $signed(st_nxt[7].t) < $signed(SEC_MIN))) begin
      st_nxt[7].ovf = 1'b1;
    end

    // stage 9: floor split of the nanosecond sum into carry seconds and rest
    st_nxt[8] = st_r[7];
    ext       = {st_r[7].nsum[32], st_r[7].nsum};
    qn_v      = 3'b100;
    base      = ns_mult(-4);
    for (int k = -3; k <= 3; k++) begin
      if ($signed(ext) >= $signed(ns_mult(k))) begin
        qn_v = 3'(k);
        base = ns_mult(k);
      end
    end
    st_nxt[8].qn = qn_v;
    st_nxt[8].rn = 30'(ext - base);

    // stage 10: carry into seconds, final range check and result select
    st_nxt[9] = st_r[8];
    rs = st_r[8].t + {{(SUM_W-3){st_r[8].qn[2]}}, st_r[8].qn};
    unique case (st_r[8].op) inside
      OP_NORM, OP_ADD, OP_SUB: begin
        st_nxt[9].lt       = 1'b0;
        st_nxt[9].eq       = 1'b0;
        st_nxt[9].gt       = 1'b0;
        st_nxt[9].res_span = '0;
        if (!st_r[8].ovf && $signed(rs) <= $signed(SEC_MAX) &&
            $signed(rs) >= $signed(SEC_MIN)) begin
          st_nxt[9].res_sec  = rs[63:0];
          st_nxt[9].res_nsec = st_r[8].rn;
        end else begin
          st_nxt[9].ovf      = 1'b1;
          st_nxt[9].res_sec  = '0;
          st_nxt[9].res_nsec = '0;
        end
      end
      OP_DIFF: begin
        st_nxt[9].lt       = 1'b0;
        st_nxt[9].eq       = 1'b0;
        st_nxt[9].gt       = 1'b0;
        st_nxt[9].res_sec  = '0;
        st_nxt[9].res_nsec = '0;
        if (st_r[8].ovf) begin
          st_nxt[9].res_span = '0;
        end
      end
      OP_CMP: begin
        st_nxt[9].ovf      = 1'b0;
        st_nxt[9].res_sec  = '0;
        st_nxt[9].res_nsec = '0;
        st_nxt[9].res_span = '0;
      end
      default: begin
        st_nxt[9].lt       = 1'b0;
        st_nxt[9].eq       = 1'b0;
        st_nxt[9].gt       = 1'b0;
        st_nxt[9].ovf      = 1'b0;
        st_nxt[9].res_sec  = '0;
        st_nxt[9].res_nsec = '0;
        st_nxt[9].res_span = '0;
      end
    endcase
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    for (int k = 0; k < PIPE_DEPTH; k++) begin
      if (adv[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // result channel
  assign out_ch.valid      = v_r[PIPE_LAST];
  assign out_ch.res_sec    = st_r[PIPE_LAST].res_sec;
  assign out_ch.res_nsec   = st_r[PIPE_LAST].res_nsec;
  assign out_ch.res_span   = st_r[PIPE_LAST].res_span;
  assign out_ch.is_less    = st_r[PIPE_LAST].lt;
  assign out_ch.is_equal   = st_r[PIPE_LAST].eq;
  assign out_ch.is_greater = st_r[PIPE_LAST].gt;
  assign out_ch.overflow   = st_r[PIPE_LAST].ovf;

  // compare requests give exactly one relation
  a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[PIPE_LAST] && st_r[PIPE_LAST].op == OP_CMP
      |-> $onehot({out_ch.is_less, out_ch.is_equal, out_ch.is_greater}))
    else $error("compare result not one-hot");

  // other requests leave the relation flags clear
  a_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[PIPE_LAST] && st_r[PIPE_LAST].op != OP_CMP
      |-> !out_ch.is_less && !out_ch.is_equal && !out_ch.is_greater)
    else $error("relation flag set outside compare");

  // overflow zeroes every numeric result
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[PIPE_LAST] && out_ch.overflow
      |-> out_ch.res_sec == '0 && out_ch.res_nsec == '0 && out_ch.res_span == '0)
    else $error("nonzero result with overflow");

  // nanoseconds of a result are normalized
  a_nsec_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[PIPE_LAST] |-> out_ch.res_nsec < NS_PER_S)
    else $error("result nanoseconds out of range");

  // an accepted request lands in the first stage
  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v_r[0])
    else $error("accepted request lost at first stage");

endmodule

FILE: verif/tb_sec_nsec_timestamp_alu_core.sv
// ----------------------------------------------------------------------------
// tb_sec_nsec_timestamp_alu_core
// Self-checking bench for the seconds plus nanoseconds timestamp unit. It
// sends directed corner cases for every request type, then mixed random
// traffic. Random idle and stall cycles are drawn on both channels. Each
// accepted request is predicted with wide exact integer arithmetic, and the
// results are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_sec_nsec_timestamp_alu_core;
  import sntsalu_pkg::*;

  // spare request codes, all result fields zero
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam logic signed [63:0] T_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] T_MIN   = 64'sh8000_0000_0000_0000;
  localparam logic signed [31:0] N32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] N32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_S   = 32'sd1000000000;
  localparam logic [29:0]        NS_TOP  = 30'd999999999;

  // exact arithmetic constants for the timestamp math
  localparam logic signed [127:0] NS_W         = 128'sd1000000000;
  localparam logic signed [127:0] I64_MAX      = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] I64_MIN      = -I64_MAX - 128'sd1;
  localparam logic signed [127:0] SEC_HI       = (128'sd1 <<< (SEC_WIDTH - 1)) - 128'sd1;
  localparam logic signed [127:0] SEC_LO       = -SEC_HI - 128'sd1;
  localparam logic signed [127:0] DIFF_SEC_LIM = 128'sd9223372035;

  typedef struct {
    logic signed [63:0] res_sec;
    logic [29:0]        res_nsec;
    logic signed [63:0] res_span;
    logic               is_less;
    logic               is_equal;
    logic               is_greater;
    logic               overflow;
  } ts_res_t;

  logic clk;
  logic rst_n;

  sntsalu_req_if req_ch ();
  sntsalu_res_if res_ch ();

  sec_nsec_timestamp_alu_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  ts_res_t expected_results[$];
  int      errors      = 0;
  int      n_checked   = 0;
  int      n_overflow  = 0;
  int      op_count[8] = '{default: 0};
  bit      src_steady  = 1'b0;
  bit      sink_steady = 1'b0;

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // run limit
  initial begin
    #2000000;
    $display("tb_sec_nsec_timestamp_alu_core: errors");
    $finish;
  end

  // low SEC_WIDTH bits of a seconds word as a signed value
  function automatic logic signed [127:0] sec_field(input logic [63:0] raw);
    logic signed [63:0] s;
    s = raw << (64 - SEC_WIDTH);
    s = s >>> (64 - SEC_WIDTH);
    return 128'(s);
  endfunction

  // expected result of one request, computed with exact wide integers
  function automatic ts_res_t predict_timestamp(input logic [2:0] op,
                                                input logic signed [63:0] a_sec_i,
                                                input logic signed [31:0] a_ns_i,
                                                input logic signed [63:0] span_i,
                                                input logic signed [63:0] b_sec_i,
                                                input logic [29:0] b_ns_i);
    ts_res_t res;
    logic signed [127:0] as, an, bs, bn, sp, base, ns, q, rm, d, total;
    logic ovf, do_norm;
    res.res_sec    = '0;
    res.res_nsec   = '0;
    res.res_span   = '0;
    res.is_less    = 1'b0;
    res.is_equal   = 1'b0;
    res.is_greater = 1'b0;
    as = sec_field(a_sec_i);
    bs = sec_field(b_sec_i);
    an = 128'(a_ns_i);
    bn = 128'(b_ns_i);
    sp = 128'(span_i);
    ovf = 1'b0;
    do_norm = 1'b0;
    base = as;
    ns = an;
    case (op) inside
      OP_NORM: do_norm = 1'b1;
      OP_ADD, OP_SUB: begin
        // truncating split of the span, seconds range checked first
        q  = sp / NS_W;
        rm = sp % NS_W;
        if (op == OP_SUB) begin
          q  = -q;
          rm = -rm;
        end
        base = as + q;
        ns   = an + rm;
        if (base > SEC_HI || base < SEC_LO) ovf = 1'b1;
        else do_norm = 1'b1;
      end
      OP_DIFF: begin
        d = as - bs;
        if (d > I64_MAX || d < I64_MIN || d > DIFF_SEC_LIM || d < -DIFF_SEC_LIM) begin
          ovf = 1'b1;
        end else begin
          total = d * NS_W + an - bn;
          if (total > I64_MAX || total < I64_MIN) ovf = 1'b1;
          else res.res_span = total[63:0];
        end
      end
      OP_CMP: begin
        res.is_less    = (as < bs) || (as == bs && an < bn);
        res.is_greater = (as > bs) || (as == bs && an > bn);
        res.is_equal   = !res.is_less && !res.is_greater;
      end
      default: ;
    endcase
    // floor normalization of the nanosecond part
    if (do_norm) begin
      q  = ns / NS_W;
      rm = ns % NS_W;
      if (rm < 0) begin
        rm = rm + NS_W;
        q  = q - 128'sd1;
      end
      base = base + q;
      if (base > SEC_HI || base < SEC_LO) begin
        ovf = 1'b1;
      end else begin
        res.res_sec  = base[63:0];
        res.res_nsec = rm[29:0];
      end
    end
    res.overflow = ovf;
    return res;
  endfunction

  // predict every accepted request
  always @(posedge clk) begin
    if (rst_n && req_ch.valid && req_ch.ready) begin
      expected_results.push_back(predict_timestamp(req_ch.req_type, req_ch.a_sec,
                                 req_ch.a_nsec, req_ch.span_ns, req_ch.b_sec,
                                 req_ch.b_nsec));
      op_count[req_ch.req_type]++;
    end
  end

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t %s mismatch: expected 0x%h, got 0x%h", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_result
    ts_res_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: expected none, got res_sec 0x%h", $time,
                 res_ch.res_sec);
        errors++;
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (want.overflow) n_overflow++;
        check_field("res_sec", want.res_sec, res_ch.res_sec);
        check_field("res_nsec", 64'(want.res_nsec), 64'(res_ch.res_nsec));
        check_field("res_span", want.res_span, res_ch.res_span);
        check_field("is_less", 64'(want.is_less), 64'(res_ch.is_less));
        check_field("is_equal", 64'(want.is_equal), 64'(res_ch.is_equal));
        check_field("is_greater", 64'(want.is_greater), 64'(res_ch.is_greater));
        check_field("overflow", 64'(want.overflow), 64'(res_ch.overflow));
      end
    end
  end

  // result side: random stall before each result
  initial begin : result_sink
    int stall;
    res_ch.ready = 1'b0;
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid === 1'b1 && rst_n));
    end
  end

  // one request, with a random idle gap in front of it
  task automatic send_req(input logic [2:0] op, input logic signed [63:0] as,
                          input logic signed [31:0] an, input logic signed [63:0] sp,
                          input logic signed [63:0] bs, input logic [29:0] bn);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= op;
    req_ch.a_sec    <= as;
    req_ch.a_nsec   <= an;
    req_ch.span_ns  <= sp;
    req_ch.b_sec    <= bs;
    req_ch.b_nsec   <= bn;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  function automatic logic signed [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [29:0] rand_bns();
    return 30'($urandom_range(0, NS_TOP));
  endfunction

  // seconds: full range, small, near both ends, medium
  function automatic logic signed [63:0] pick_sec();
    logic signed [63:0] v;
    case ($urandom_range(0, 4))
      0: v = rand64();
      1: begin
        v = 64'($urandom_range(0, 2000000));
        v = v - 64'sd1000000;
      end
      2: v = T_MAX - 64'($urandom_range(0, 20));
      3: v = T_MIN + 64'($urandom_range(0, 20));
      default: v = rand64() >>> $urandom_range(20, 40);
    endcase
    return v;
  endfunction

  // span: full range, extremes, near whole seconds, scaled
  function automatic logic signed [63:0] pick_span();
    logic signed [63:0] v;
    case ($urandom_range(0, 4))
      0: v = rand64();
      1: v = T_MAX - 64'($urandom_range(0, 3));
      2: v = T_MIN + 64'($urandom_range(0, 3));
      3: begin
        v = 64'($urandom_range(0, 40)) * 64'd1000000000 + 64'($urandom_range(0, 2));
        v = v - 64'sd1;
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = rand64() >>> $urandom_range(1, 62);
    endcase
    return v;
  endfunction

  // raw nanoseconds for normalize: any 32-bit value, often near whole seconds
  function automatic logic signed [31:0] pick_ns_raw();
    logic signed [63:0] w;
    case ($urandom_range(0, 3))
      0: w = 64'($signed($urandom));
      1: begin
        w = 64'($urandom_range(0, 4)) * 64'd1000000000 - 64'sd2000000000;
        w = w + 64'($urandom_range(0, 4)) - 64'sd2;
      end
      2: w = 64'($urandom_range(0, NS_TOP));
      default: w = 64'($urandom_range(0, 1) ? N32_MAX - $urandom_range(0, 3)
                                            : N32_MIN + $urandom_range(0, 3));
    endcase
    return w[31:0];
  endfunction

  // nanoseconds of a point, mostly normalized, sometimes raw
  function automatic logic signed [31:0] pick_ns_point();
    case ($urandom_range(0, 15))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'(NS_TOP) : 32'sd0;
      default: return $urandom_range(0, NS_TOP);
    endcase
  endfunction

  task automatic test_normalize();
    send_req(OP_NORM, 64'sd5, ONE_S, rand64(), rand64(), rand_bns());
    send_req(OP_NORM, 64'sd5, -32'sd1, rand64(), rand64(), rand_bns());
    send_req(OP_NORM, T_MAX, N32_MAX, rand64(), rand64(), rand_bns());
    send_req(OP_NORM, T_MIN, N32_MIN, rand64(), rand64(), rand_bns());
    send_req(OP_NORM, T_MAX, 32'(NS_TOP), rand64(), rand64(), rand_bns());
    send_req(OP_NORM, T_MIN, 32'sd0, rand64(), rand64(), rand_bns());
  endtask

  task automatic test_span_add_sub();
    send_req(OP_ADD, 64'sd0, 32'sd0, T_MAX, rand64(), rand_bns());
    send_req(OP_ADD, T_MAX, 32'(NS_TOP), 64'sd1, rand64(), rand_bns());
    send_req(OP_SUB, 64'sd0, 32'sd0, T_MIN, rand64(), rand_bns());
    send_req(OP_SUB, T_MIN, 32'sd0, 64'sd1, rand64(), rand_bns());
    send_req(OP_ADD, T_MIN + 64'sd5, 32'sd0, T_MIN, rand64(), rand_bns());
    send_req(OP_ADD, -64'sd1, 32'sd500000000, -64'sd1500000000, rand64(), rand_bns());
  endtask

  task automatic test_difference();
    // seconds difference at and past the limit, nanosecond sum overflow
    send_req(OP_DIFF, 64'sd9223372035, 32'(NS_TOP), rand64(), 64'sd0, 30'd0);
    send_req(OP_DIFF, 64'sd9223372035, N32_MAX, rand64(), 64'sd0, 30'd0);
    send_req(OP_DIFF, 64'sd9223372036, 32'sd0, rand64(), 64'sd0, 30'd0);
    send_req(OP_DIFF, -64'sd9223372035, 32'sd0, rand64(), 64'sd0, NS_TOP);
    send_req(OP_DIFF, -64'sd9223372035, N32_MIN, rand64(), 64'sd0, NS_TOP);
    // seconds difference leaving the 64-bit range, then equal seconds at T_MIN
    send_req(OP_DIFF, T_MAX, 32'sd0, rand64(), T_MIN, 30'd0);
    send_req(OP_DIFF, T_MIN, 32'sd5, rand64(), T_MIN, 30'd7);
  endtask

  task automatic test_compare();
    send_req(OP_CMP, 64'sd1, 32'sd5, rand64(), 64'sd1, 30'd5);
    send_req(OP_CMP, 64'sd1, 32'sd4, rand64(), 64'sd1, 30'd5);
    send_req(OP_CMP, T_MAX, 32'sd0, rand64(), T_MIN, NS_TOP);
    send_req(OP_CMP, T_MIN, 32'sd0, rand64(), T_MIN, 30'd0);
    // unnormalized negative nanoseconds of the first point
    send_req(OP_CMP, 64'sd0, -32'sd1, rand64(), 64'sd0, 30'd0);
  endtask

  task automatic test_spare_codes();
    for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++) begin
      send_req(3'(c), rand64(), $urandom, rand64(), rand64(), rand_bns());
    end
  endtask

  // mixed random requests; flags remove idling on either side
  task automatic test_random_traffic(input int n, input bit src_hold, input bit snk_hold);
    logic [2:0]         op;
    logic signed [63:0] as, sp, bs, dl;
    logic signed [31:0] an;
    logic [29:0]        bn;
    src_steady  = src_hold;
    sink_steady = snk_hold;
    repeat (n) begin
      if ($urandom_range(0, 31) == 0) op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      else op = 3'($urandom_range(int'(OP_NORM), int'(OP_CMP)));
      as = pick_sec();
      an = (op == OP_NORM) ? pick_ns_raw() : pick_ns_point();
      sp = pick_span();
      bs = rand64();
      bn = rand_bns();
      if (op == OP_DIFF) begin
        // second point placed near the difference limit, close by, or drawn freely
        case ($urandom_range(0, 3))
          0: begin
            dl = 64'sd9223372034 + 64'($urandom_range(0, 2));
            if ($urandom_range(0, 1)) dl = -dl;
            bs = as - dl;
          end
          1: bs = as - (rand64() >>> $urandom_range(30, 62));
          2: bs = pick_sec();
          default: ;
        endcase
      end else if (op == OP_CMP) begin
        if ($urandom_range(0, 1)) bs = as;
        if ($urandom_range(0, 2) == 0) an = $signed({2'b00, bn});
      end
      send_req(op, as, an, sp, bs, bn);
    end
  endtask

  // main sequence
  initial begin
    rst_n           = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = OP_NORM;
    req_ch.a_sec    = '0;
    req_ch.a_nsec   = '0;
    req_ch.span_ns  = '0;
    req_ch.b_sec    = '0;
    req_ch.b_nsec   = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_normalize();
    test_span_add_sub();
    test_difference();
    test_compare();
    test_spare_codes();
    test_random_traffic(450, 1'b0, 1'b0);
    test_random_traffic(450, 1'b1, 1'b0);
    test_random_traffic(450, 1'b0, 1'b1);
    test_random_traffic(450, 1'b1, 1'b1);
    req_ch.valid <= 1'b0;

    // drain the pipeline
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2 * PIPE_DEPTH) @(posedge clk);

    $display("requests: normalize %0d, add %0d, sub %0d, diff %0d, compare %0d, spare %0d",
             op_count[OP_NORM], op_count[OP_ADD], op_count[OP_SUB], op_count[OP_DIFF],
             op_count[OP_CMP], op_count[5] + op_count[6] + op_count[7]);
    $display("results compared: %0d, of which %0d flagged overflow", n_checked, n_overflow);
    if (errors == 0) begin
      $display("tb_sec_nsec_timestamp_alu_core: clean");
    end else begin
      $display("tb_sec_nsec_timestamp_alu_core: errors");
    end
    $finish;
  end

endmodule
